// File: rtl/core/cle_pkg.sv
// Shared types, constants and the microcode table of the console line editor.
`default_nettype none

package cle_pkg;

    // Line store geometry and fixed field widths.
    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;

    // Reset value of the line length limit register.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(32);

    // Received byte codes with a meaning of their own.
    localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CHR_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;

    // Result channel codes.
    localparam logic CH_ECHO = 1'b0;
    localparam logic CH_LINE = 1'b1;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ECHO,
        S_BS1,
        S_SP,
        S_BS2,
        S_LINE_RD,
        S_LINE_OUT,
        S_TERM
    } t_step;

    // What a step waits for before it executes.
    typedef enum logic [1:0] {
        W_NONE,
        W_INPUT,
        W_OUT
    } t_wait;

    // Which result a step loads into the output register.
    typedef enum logic [2:0] {
        E_NONE,
        E_RX,
        E_BS,
        E_SP,
        E_LINE,
        E_TERM
    } t_emit;

    // Update of the fill position.
    typedef enum logic [1:0] {
        F_KEEP,
        F_STORE,
        F_DEC,
        F_CLEAR
    } t_fill;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_IDX_END
    } t_jump;

    typedef struct packed {
        t_wait wt;
        t_emit em;
        t_fill fl;
        logic  idx_clr;
        logic  idx_inc;
        t_jump jp;
        t_step tgt;
    } t_cw;

    // Control store: one control word per step.
    function automatic t_cw ucode_rom(input t_step s);
        t_cw cw;
        cw = '{wt: W_NONE, em: E_NONE, fl: F_KEEP, idx_clr: 1'b0,
               idx_inc: 1'b0, jp: J_GOTO, tgt: S_IDLE};
        unique case (s)
            S_IDLE: begin
                cw.wt = W_INPUT;
                cw.jp = J_NEXT;
            end
            S_DECODE: begin
                cw.idx_clr = 1'b1;
                cw.jp      = J_DISPATCH;
            end
            S_ECHO: begin
                cw.wt  = W_OUT;
                cw.em  = E_RX;
                cw.fl  = F_STORE;
                cw.tgt = S_IDLE;
            end
            S_BS1: begin
                cw.wt = W_OUT;
                cw.em = E_BS;
                cw.jp = J_NEXT;
            end
            S_SP: begin
                cw.wt = W_OUT;
                cw.em = E_SP;
                cw.jp = J_NEXT;
            end
            S_BS2: begin
                cw.wt  = W_OUT;
                cw.em  = E_BS;
                cw.fl  = F_DEC;
                cw.tgt = S_IDLE;
            end
            S_LINE_RD: begin
                cw.jp  = J_IDX_END;
                cw.tgt = S_TERM;
            end
            S_LINE_OUT: begin
                cw.wt      = W_OUT;
                cw.em      = E_LINE;
                cw.idx_inc = 1'b1;
                cw.tgt     = S_LINE_RD;
            end
            S_TERM: begin
                cw.wt  = W_OUT;
                cw.em  = E_TERM;
                cw.fl  = F_CLEAR;
                cw.tgt = S_IDLE;
            end
            default: begin
                cw.tgt = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/console_line_editor.sv
// Top level of the console line editor: microcoded sequencer, line store and output register.
//
// Usage: the receive channel (i_rx_valid, o_rx_stall, i_rx_byte) takes one console byte
// per request. The result channel (o_out_valid, i_out_stall and the four payload ports)
// delivers echo bytes on channel 0 and completed line characters on channel 1; the
// last line request carries o_last high, data 0 and the line length.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_max_line_length) is always
// ready and sets the most characters a line may hold; write it only while idle.
// Sequence: an ordinary byte passes the accept, decode and echo steps. An erase passes accept,
// decode, backspace, space and backspace, or only accept and decode on an empty line. A carriage
// return passes accept and decode, then reads and sends each stored character in turn, each one
// read from the line store through a registered read port before it is sent, and then sends the
// terminator. A result appears on the ports the cycle after the step that produces it.
// One byte is worked on at a time: o_rx_stall is low only while the step counter
// rests at its idle step.
// Reset (synchronous, active low) empties the line, sets the limit to 32 and drops
// any pending result. When the receiver stalls, the output register holds its request
// and the sequencer waits at the step that wants to send next.
`default_nettype none

module console_line_editor
    import cle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Receive channel.
    input  wire logic              i_rx_valid,
    output logic                   o_rx_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    // Result channel.
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_channel,
    output logic [BYTE_W-1:0]      o_data_byte,
    output logic                   o_last,
    output logic [LEN_W-1:0]       o_line_length,
    // Configuration channel.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [LEN_W-1:0]  i_cfg_max_line_length
);

    // Sequencer state.
    t_step r_pc;
    t_step n_pc;
    t_cw   cw;

    // Datapath registers.
    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;
    logic [LEN_W-1:0]  r_idx;
    logic [LEN_W-1:0]  n_idx;
    logic [LEN_W-1:0]  r_max_len;
    logic [LEN_W-1:0]  limit;

    // Line store with a registered read port.
    logic [BYTE_W-1:0] mem [LINE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Output register.
    logic              r_out_valid;
    logic              r_out_channel;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;
    logic [LEN_W-1:0]  r_out_len;

    logic rx_accept;
    logic out_free;
    logic step_ok;
    logic is_cr;
    logic is_erase;
    logic room;
    logic store_en;
    logic emit_en;

    assign rx_accept = i_rx_valid && !o_rx_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_cr     = (r_byte == CHR_CR);
    assign is_erase  = (r_byte == CHR_BS) || (r_byte == CHR_DEL);

    // A limit above the store depth acts as the depth.
    assign limit = (r_max_len > LEN_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : r_max_len;
    assign room  = (r_fill < limit);

    // Control word fetch and the step's wait condition.
    always_comb begin
        cw = ucode_rom(r_pc);
        unique case (cw.wt)
            W_NONE:  step_ok = 1'b1;
            W_INPUT: step_ok = i_rx_valid;
            W_OUT:   step_ok = out_free;
            default: step_ok = 1'b0;
        endcase
    end

    // Next step.
    always_comb begin
        n_pc = r_pc;
        if (step_ok) begin
            unique case (cw.jp)
                J_NEXT:    n_pc = t_step'(r_pc + 1'b1);
                J_GOTO:    n_pc = cw.tgt;
                J_IDX_END: n_pc = (r_idx == r_fill) ? cw.tgt : t_step'(r_pc + 1'b1);
                J_DISPATCH: begin
                    if (is_cr) begin
                        n_pc = S_LINE_RD;
                    end else if (is_erase) begin
                        n_pc = (r_fill != '0) ? S_BS1 : S_IDLE;
                    end else begin
                        n_pc = S_ECHO;
                    end
                end
                default:   n_pc = S_IDLE;
            endcase
        end
    end

    // Datapath controls decoded from the control word.
    always_comb begin
        emit_en  = step_ok && (cw.em != E_NONE);
        store_en = step_ok && (cw.fl == F_STORE) && room;
        n_fill   = r_fill;
        n_idx    = r_idx;
        if (step_ok) begin
            unique case (cw.fl)
                F_KEEP:  n_fill = r_fill;
                F_STORE: n_fill = room ? r_fill + 1'b1 : r_fill;
                F_DEC:   n_fill = r_fill - 1'b1;
                F_CLEAR: n_fill = '0;
                default: n_fill = r_fill;
            endcase
            if (cw.idx_clr) begin
                n_idx = '0;
            end else if (cw.idx_inc) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    assign o_rx_stall = (r_pc != S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= S_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            r_pc   <= n_pc;
            r_fill <= n_fill;
            r_idx  <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_cfg_max_line_length;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // The received byte is held for decode and echo.
    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_byte <= i_rx_byte;
        end
    end

    // Line store: written at the fill position, read at the readout index.
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            mem[r_fill[ADDR_W-1:0]] <= r_byte;
        end
        r_rd_data <= mem[r_idx[ADDR_W-1:0]];
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out_channel <= CH_ECHO;
            r_out_last    <= 1'b0;
            r_out_len     <= '0;
            case (cw.em)
                E_RX: begin
                    r_out_data <= r_byte;
                end
                E_BS: begin
                    r_out_data <= CHR_BS;
                end
                E_SP: begin
                    r_out_data <= CHR_SPACE;
                end
                E_LINE: begin
                    r_out_channel <= CH_LINE;
                    r_out_data    <= r_rd_data;
                end
                E_TERM: begin
                    r_out_channel <= CH_LINE;
                    r_out_data    <= CHR_NUL;
                    r_out_last    <= 1'b1;
                    r_out_len     <= r_fill;
                end
                default: begin
                    r_out_data <= CHR_NUL;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel     = r_out_channel;
    assign o_data_byte   = r_out_data;
    assign o_last        = r_out_last;
    assign o_line_length = r_out_len;

`ifndef NO_ASSERTIONS
    // The fill position never runs past the store.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(LINE_DEPTH))
        else $error("fill position beyond line store");

    // An accepted byte always moves the sequencer to decode.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_accept |=> (r_pc == S_DECODE))
        else $error("accepted byte not decoded");

    // The last erase echo removes exactly one character.
    a_erase_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_BS2 && out_free) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("erase did not remove one character");

    // A terminator request is a line request with a zero data byte.
    a_term_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_channel == CH_LINE && o_data_byte == CHR_NUL))
        else $error("malformed line terminator");
`endif

endmodule

`default_nettype wire
